>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ABTT_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ABTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/abtt_pkg.sv
`default_nettype none

package abtt_pkg;

    // Tree storage
    localparam int CAPACITY = 63;
    localparam int ADDR_W   = $clog2(CAPACITY);

    // Field widths
    localparam int OP_W   = 3;
    localparam int VAL_W  = 8;
    localparam int IDX_W  = 6;
    localparam int KIND_W = 2;
    localparam int STS_W  = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    // Item opcodes
    localparam logic [OP_W-1:0] OP_SET_ROOT  = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_LEFT  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_RIGHT = 3'd2;
    localparam logic [OP_W-1:0] OP_PREORDER  = 3'd3;
    localparam logic [OP_W-1:0] OP_INORDER   = 3'd4;
    localparam logic [OP_W-1:0] OP_POSTORDER = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VISIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    // Set status codes
    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NO_PARENT = 2'd1;
    localparam logic [STS_W-1:0] ST_BEYOND    = 2'd2;

    // Read address select
    typedef enum logic [2:0] {
        RD_ROOT   = 3'd0,
        RD_PARENT = 3'd1,
        RD_LEFT   = 3'd2,
        RD_RIGHT  = 3'd3,
        RD_UP     = 3'd4
    } rd_sel_t;

    // Walk order
    typedef enum logic [1:0] {
        ORD_PRE  = 2'd0,
        ORD_IN   = 2'd1,
        ORD_POST = 2'd2
    } order_t;

    // Controller to datapath
    typedef struct packed {
        logic    take;
        rd_sel_t rd_sel;
        logic    load_cur;
        logic    set_root;
        logic    set_child;
        logic    emit;
        logic    finish;
    } abtt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic occ;
        logic cur_root;
        logic cur_odd;
        logic out_free;
        logic held_vld;
    } abtt_sts_t;

endpackage

`default_nettype wire

>>> hdl/abtt_ram.sv
`default_nettype none

module abtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/abtt_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module abtt_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [abtt_pkg::OP_W-1:0]     in_opcode,
    input  wire logic [abtt_pkg::VAL_W-1:0]    in_value,
    input  wire logic [abtt_pkg::IDX_W-1:0]    in_parent,
    input  wire logic                          cfg_we,
    input  wire logic [abtt_pkg::IDX_W-1:0]    cfg_wdata,
    input  wire abtt_pkg::abtt_cmd_t           cmd,
    output abtt_pkg::abtt_sts_t                sts,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [abtt_pkg::KIND_W-1:0]        m_kind,
    output logic [abtt_pkg::STS_W-1:0]         m_status,
    output logic [abtt_pkg::VAL_W-1:0]         m_value,
    output logic [abtt_pkg::IDX_W-1:0]         m_index,
    output logic                               m_last
);

    localparam int IDX_W  = abtt_pkg::IDX_W;
    localparam int VAL_W  = abtt_pkg::VAL_W;
    localparam int ADDR_W = abtt_pkg::ADDR_W;

    logic [IDX_W-1:0] tree_size_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] parent_reg;
    logic             right_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [VAL_W-1:0] cur_val_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_inrng_reg;
    logic             rd_vld_reg;
    logic             held_vld_reg;
    logic [IDX_W-1:0] held_idx_reg;
    logic [VAL_W-1:0] held_val_reg;
    logic [abtt_pkg::CAPACITY-1:0] vld_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [abtt_pkg::KIND_W-1:0] m_kind_reg,   m_kind_next;
    logic [abtt_pkg::STS_W-1:0]  m_status_reg, m_status_next;
    logic [VAL_W-1:0]            m_value_reg,  m_value_next;
    logic [IDX_W-1:0]            m_index_reg,  m_index_next;
    logic                        m_last_reg,   m_last_next;

    logic [IDX_W-1:0]  used_size;
    logic [IDX_W:0]    rd_idx_w;
    logic [IDX_W-1:0]  cur_m1;
    logic              rd_inrng;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  ram_rdata;
    logic              occ;
    logic [IDX_W:0]    child_idx;
    logic              child_oob;
    logic [abtt_pkg::STS_W-1:0] child_status;
    logic [abtt_pkg::STS_W-1:0] root_status;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              out_free;
    logic              out_load;

    // Slots in use, capped at the store depth
    assign used_size = (tree_size_reg < abtt_pkg::CAP_IDX) ? tree_size_reg : abtt_pkg::CAP_IDX;

    // Read index select
    assign cur_m1 = cur_idx_reg - IDX_W'(1);
    always_comb begin
        unique case (cmd.rd_sel)
            abtt_pkg::RD_ROOT:   rd_idx_w = '0;
            abtt_pkg::RD_PARENT: rd_idx_w = {1'b0, parent_reg};
            abtt_pkg::RD_LEFT:   rd_idx_w = {cur_idx_reg, 1'b1};
            abtt_pkg::RD_RIGHT:  rd_idx_w = {cur_idx_reg, 1'b0} + (IDX_W+1)'(2);
            abtt_pkg::RD_UP:     rd_idx_w = {2'b00, cur_m1[IDX_W-1:1]};
            default:             rd_idx_w = '0;
        endcase
    end

    // Bounds check before the read; out-of-range reads park on slot zero
    assign rd_inrng = rd_idx_w < {1'b0, used_size};
    assign rd_addr  = rd_inrng ? rd_idx_w[ADDR_W-1:0] : '0;

    abtt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (abtt_pkg::CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (val_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Slot occupied: in range, written since reset, nonzero
    assign occ = rd_inrng_reg && rd_vld_reg && (ram_rdata != '0);

    // Set checks
    assign child_idx   = {parent_reg, 1'b0} + (right_reg ? (IDX_W+1)'(2) : (IDX_W+1)'(1));
    assign child_oob   = child_idx >= {1'b0, used_size};
    assign root_status = (used_size == '0) ? abtt_pkg::ST_BEYOND : abtt_pkg::ST_OK;

    always_comb begin
        priority if (!rd_inrng_reg) begin
            child_status = abtt_pkg::ST_BEYOND;
        end else if (!occ) begin
            child_status = abtt_pkg::ST_NO_PARENT;
        end else if (child_oob) begin
            child_status = abtt_pkg::ST_BEYOND;
        end else begin
            child_status = abtt_pkg::ST_OK;
        end
    end

    assign wr_en   = (cmd.set_root && (root_status == abtt_pkg::ST_OK)) ||
                     (cmd.set_child && (child_status == abtt_pkg::ST_OK));
    assign wr_addr = cmd.set_root ? '0 : child_idx[ADDR_W-1:0];

    // Output register load
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        out_load      = 1'b0;
        m_kind_next   = m_kind_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_index_next  = m_index_reg;
        m_last_next   = m_last_reg;
        priority if (cmd.set_root || cmd.set_child) begin
            out_load      = 1'b1;
            m_kind_next   = abtt_pkg::KIND_STATUS;
            m_status_next = cmd.set_root ? root_status : child_status;
            m_value_next  = '0;
            m_index_next  = '0;
            m_last_next   = 1'b1;
        end else if ((cmd.emit || cmd.finish) && held_vld_reg) begin
            out_load      = 1'b1;
            m_kind_next   = abtt_pkg::KIND_VISIT;
            m_status_next = abtt_pkg::ST_OK;
            m_value_next  = held_val_reg;
            m_index_next  = held_idx_reg;
            m_last_next   = cmd.finish;
        end else if (cmd.finish) begin
            out_load      = 1'b1;
            m_kind_next   = abtt_pkg::KIND_EMPTY;
            m_status_next = abtt_pkg::ST_OK;
            m_value_next  = '0;
            m_index_next  = '0;
            m_last_next   = 1'b1;
        end else begin
            out_load      = 1'b0;
        end
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tree_size_reg <= abtt_pkg::CAP_IDX;
            vld_reg       <= '0;
            held_vld_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                tree_size_reg <= cfg_wdata;
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.emit) begin
                held_vld_reg <= 1'b1;
            end else if (cmd.finish) begin
                held_vld_reg <= 1'b0;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            val_reg    <= in_value;
            parent_reg <= in_parent;
            right_reg  <= (in_opcode == abtt_pkg::OP_SET_RIGHT);
        end
        rd_idx_reg   <= rd_idx_w[IDX_W-1:0];
        rd_inrng_reg <= rd_inrng;
        rd_vld_reg   <= vld_reg[rd_addr];
        if (cmd.load_cur) begin
            cur_idx_reg <= rd_idx_reg;
            cur_val_reg <= ram_rdata;
        end
        if (cmd.emit) begin
            held_idx_reg <= cur_idx_reg;
            held_val_reg <= cur_val_reg;
        end
        m_kind_reg   <= m_kind_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_index_reg  <= m_index_next;
        m_last_reg   <= m_last_next;
    end

    // Status to controller
    assign sts.occ      = occ;
    assign sts.cur_root = (cur_idx_reg == '0);
    assign sts.cur_odd  = cur_idx_reg[0];
    assign sts.out_free = out_free;
    assign sts.held_vld = held_vld_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_kind   = m_kind_reg;
    assign m_status = m_status_reg;
    assign m_value  = m_value_reg;
    assign m_index  = m_index_reg;
    assign m_last   = m_last_reg;

    `ABTT_ASSERT(a_load_free, aclk, aresetn, out_load, out_free, "output overwritten while stalled")
    `ABTT_ASSERT(a_cur_inrng, aclk, aresetn, cmd.load_cur, rd_inrng_reg, "node loaded from out-of-range slot")
    `ABTT_ASSERT_NEXT(a_fin_last, aclk, aresetn, cmd.finish, (m_tvalid_reg && m_last_reg), "walk end without last result")

endmodule

`default_nettype wire

>>> hdl/abtt_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module abtt_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    input  wire logic [abtt_pkg::OP_W-1:0] in_opcode,
    output logic                           s_tready,
    input  wire abtt_pkg::abtt_sts_t       sts,
    output abtt_pkg::abtt_cmd_t            cmd
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'h0001,
        S_SET_ROOT  = 13'h0002,
        S_SET_PRD   = 13'h0004,
        S_SET_PCHK  = 13'h0008,
        S_CHK_ROOT  = 13'h0010,
        S_CHK_LEFT  = 13'h0020,
        S_CHK_RIGHT = 13'h0040,
        S_PRE       = 13'h0080,
        S_IN        = 13'h0100,
        S_POST      = 13'h0200,
        S_UP_LEFT   = 13'h0400,
        S_UP_RIGHT  = 13'h0800,
        S_FIN       = 13'h1000
    } state_t;

    state_t                  state_reg, state_next;
    abtt_pkg::order_t        order_reg, order_next;
    logic                    visit_here;
    logic                    stall;

    // Visit rule for the node-phase states
    always_comb begin
        unique case (state_reg)
            S_PRE:   visit_here = (order_reg == abtt_pkg::ORD_PRE);
            S_IN:    visit_here = (order_reg == abtt_pkg::ORD_IN);
            S_POST:  visit_here = (order_reg == abtt_pkg::ORD_POST);
            default: visit_here = 1'b0;
        endcase
    end

    // A visit pushes the held node out, so it waits on a free output slot
    assign stall = visit_here && sts.held_vld && !sts.out_free;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        order_next    = order_reg;
        s_tready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.rd_sel    = abtt_pkg::RD_ROOT;
        cmd.load_cur  = 1'b0;
        cmd.set_root  = 1'b0;
        cmd.set_child = 1'b0;
        cmd.emit      = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    unique case (in_opcode)
                        abtt_pkg::OP_SET_ROOT: state_next = S_SET_ROOT;
                        abtt_pkg::OP_SET_LEFT,
                        abtt_pkg::OP_SET_RIGHT: state_next = S_SET_PRD;
                        abtt_pkg::OP_PREORDER: begin
                            order_next = abtt_pkg::ORD_PRE;
                            state_next = S_CHK_ROOT;
                        end
                        abtt_pkg::OP_INORDER: begin
                            order_next = abtt_pkg::ORD_IN;
                            state_next = S_CHK_ROOT;
                        end
                        abtt_pkg::OP_POSTORDER: begin
                            order_next = abtt_pkg::ORD_POST;
                            state_next = S_CHK_ROOT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SET_ROOT: begin
                if (sts.out_free) begin
                    cmd.set_root = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SET_PRD: begin
                cmd.rd_sel = abtt_pkg::RD_PARENT;
                state_next = S_SET_PCHK;
            end
            S_SET_PCHK: begin
                // keep the parent read alive while the output is stalled
                cmd.rd_sel = abtt_pkg::RD_PARENT;
                if (sts.out_free) begin
                    cmd.set_child = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CHK_ROOT: begin
                cmd.load_cur = sts.occ;
                state_next   = sts.occ ? S_PRE : S_FIN;
            end
            S_CHK_LEFT: begin
                cmd.load_cur = sts.occ;
                state_next   = sts.occ ? S_PRE : S_IN;
            end
            S_CHK_RIGHT: begin
                cmd.load_cur = sts.occ;
                state_next   = sts.occ ? S_PRE : S_POST;
            end
            S_PRE: begin
                cmd.rd_sel = abtt_pkg::RD_LEFT;
                if (!stall) begin
                    cmd.emit   = visit_here;
                    state_next = S_CHK_LEFT;
                end
            end
            S_IN: begin
                cmd.rd_sel = abtt_pkg::RD_RIGHT;
                if (!stall) begin
                    cmd.emit   = visit_here;
                    state_next = S_CHK_RIGHT;
                end
            end
            S_POST: begin
                cmd.rd_sel = abtt_pkg::RD_UP;
                if (!stall) begin
                    cmd.emit = visit_here;
                    // odd slot is a left child
                    if (sts.cur_root) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = sts.cur_odd ? S_UP_LEFT : S_UP_RIGHT;
                    end
                end
            end
            S_UP_LEFT: begin
                cmd.load_cur = 1'b1;
                state_next   = S_IN;
            end
            S_UP_RIGHT: begin
                cmd.load_cur = 1'b1;
                state_next   = S_POST;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            order_reg <= abtt_pkg::ORD_PRE;
        end else begin
            state_reg <= state_next;
            order_reg <= order_next;
        end
    end

    `ABTT_ASSERT(a_up_occ, aclk, aresetn, ((state_reg == S_UP_LEFT) || (state_reg == S_UP_RIGHT)), sts.occ, "parent slot empty on climb")
    `ABTT_ASSERT(a_idle_clear, aclk, aresetn, (state_reg == S_IDLE), !sts.held_vld, "held node left over after walk")

endmodule

`default_nettype wire

>>> hdl/array_binary_tree_traversal_top.sv
// Set root: after the accept, the status result is loaded in S_SET_ROOT once the output
// register is free. Set child: the parent slot is read first (S_SET_PRD, S_SET_PCHK),
// then the status is loaded. Walk of n nodes: each node takes a probe, pre, in and post step
// plus, below the root, a climb to its parent, and each empty child probe adds one step. The
// last result is loaded in S_FIN. A full output register stalls the step that loads it.
// aresetn (synchronous, active low) clears all slot-valid flags and sets tree_size to 63.
`default_nettype none

module array_binary_tree_traversal_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] opcode, [10:3] node_value, [16:11] parent_index, [23:17] zero
    input  wire logic [abtt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] result_kind, [3:2] status_code, [11:4] visited_value,
    // [17:12] visited_index, [23:18] zero
    output logic [abtt_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [abtt_pkg::IDX_W-1:0]        cfg_wdata
);

    abtt_pkg::abtt_cmd_t cmd;
    abtt_pkg::abtt_sts_t sts;

    logic [abtt_pkg::OP_W-1:0]   in_opcode;
    logic [abtt_pkg::VAL_W-1:0]  in_value;
    logic [abtt_pkg::IDX_W-1:0]  in_parent;
    logic [abtt_pkg::KIND_W-1:0] m_kind;
    logic [abtt_pkg::STS_W-1:0]  m_status;
    logic [abtt_pkg::VAL_W-1:0]  m_value;
    logic [abtt_pkg::IDX_W-1:0]  m_index;

    // Input unpacking
    assign in_opcode = s_tdata[2:0];
    assign in_value  = s_tdata[10:3];
    assign in_parent = s_tdata[16:11];

    abtt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .in_opcode (in_opcode),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    abtt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_opcode (in_opcode),
        .in_value  (in_value),
        .in_parent (in_parent),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_kind    (m_kind),
        .m_status  (m_status),
        .m_value   (m_value),
        .m_index   (m_index),
        .m_last    (m_tlast)
    );

    // Output packing
    assign m_tdata = {6'b000000, m_index, m_value, m_status, m_kind};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import abtt_pkg::*;

    localparam int          RANDOM_ITEMS  = 430;
    localparam int          PHASES        = 8;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          TAIL_CYCLES   = 64;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    // Opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // One result item as the block reports it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STS_W-1:0]  status;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  index;
        logic              last;
    } tree_result_t;

    // Directed stimulus row: either a size write or an item, with an optional
    // hand-typed single result
    typedef struct packed {
        logic              is_cfg;
        logic [IDX_W-1:0]  size;
        logic [OP_W-1:0]   op;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  parent;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [STS_W-1:0]  status;
    } plan_row_t;

    localparam int PLAN_LEN = 26;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{1'b0, 6'd0,  OP_PREORDER,  8'd0,   6'd0,  1'b1, KIND_EMPTY,  ST_OK},
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'd9,   6'd0,  1'b1, KIND_STATUS, ST_NO_PARENT},
        '{1'b0, 6'd0,  OP_SET_RIGHT, 8'd9,   6'd63, 1'b1, KIND_STATUS, ST_BEYOND},
        '{1'b0, 6'd0,  OP_SET_ROOT,  8'd255, 6'd0,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'd1,   6'd0,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_RIGHT, 8'd128, 6'd0,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'h55,  6'd1,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_RIGHT, 8'hAA,  6'd2,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'd7,   6'd30, 1'b1, KIND_STATUS, ST_NO_PARENT},
        '{1'b0, 6'd0,  OP_PREORDER,  8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_INORDER,   8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_POSTORDER, 8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SPARE_6,   8'd255, 6'd63, 1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SPARE_7,   8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        // zero write empties slot 3
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'd0,   6'd1,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_INORDER,   8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_ROOT,  8'd0,   6'd0,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_POSTORDER, 8'd0,   6'd0,  1'b1, KIND_EMPTY,  ST_OK},
        '{1'b0, 6'd0,  OP_SET_ROOT,  8'h3C,  6'd0,  1'b1, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_PREORDER,  8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        // zero used size: root rejected, walk finds nothing
        '{1'b1, 6'd0,  OP_SET_ROOT,  8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_ROOT,  8'd5,   6'd0,  1'b1, KIND_STATUS, ST_BEYOND},
        '{1'b0, 6'd0,  OP_PREORDER,  8'd0,   6'd0,  1'b1, KIND_EMPTY,  ST_OK},
        // three slots: child of slot 1 falls outside
        '{1'b1, 6'd3,  OP_SET_ROOT,  8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK},
        '{1'b0, 6'd0,  OP_SET_LEFT,  8'd4,   6'd1,  1'b1, KIND_STATUS, ST_BEYOND},
        '{1'b0, 6'd0,  OP_INORDER,   8'd0,   6'd0,  1'b0, KIND_STATUS, ST_OK}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [IDX_W-1:0]     cfg_wdata = '0;

    // Tree mirror
    logic [VAL_W-1:0] node_store [CAPACITY];
    logic [IDX_W-1:0] tree_size;
    int               walk_path [$];
    tree_result_t     fresh_results [$];
    tree_result_t     awaited_results [$];

    int          fault_count = 0;
    int unsigned cycle_count = 0;
    int          rx_hold     = 0;
    bit          quiet_mode  = 1'b0;

    always #4 aclk = ~aclk;

    array_binary_tree_traversal_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic int used_slots();
        int s;
        s = tree_size;
        return (s < CAPACITY) ? s : CAPACITY;
    endfunction

    function automatic bit slot_live(int idx);
        return (idx < used_slots()) && (node_store[idx] != '0);
    endfunction

    // Slot order of a walk from the root, kept in walk_path
    function automatic void collect_walk(order_t ord);
        int pend [$];
        int rev [$];
        int cur;
        walk_path.delete();
        case (ord)
            ORD_PRE: begin
                if (slot_live(0)) pend.push_back(0);
                while (pend.size() != 0) begin
                    cur = pend.pop_back();
                    walk_path.push_back(cur);
                    if (slot_live(2 * cur + 2)) pend.push_back(2 * cur + 2);
                    if (slot_live(2 * cur + 1)) pend.push_back(2 * cur + 1);
                end
            end
            ORD_IN: begin
                cur = 0;
                while (slot_live(cur) || pend.size() != 0) begin
                    while (slot_live(cur)) begin
                        pend.push_back(cur);
                        cur = 2 * cur + 1;
                    end
                    cur = pend.pop_back();
                    walk_path.push_back(cur);
                    cur = 2 * cur + 2;
                end
            end
            default: begin
                // root-right-left, then reversed
                if (slot_live(0)) pend.push_back(0);
                while (pend.size() != 0) begin
                    cur = pend.pop_back();
                    rev.push_back(cur);
                    if (slot_live(2 * cur + 1)) pend.push_back(2 * cur + 1);
                    if (slot_live(2 * cur + 2)) pend.push_back(2 * cur + 2);
                end
                for (int k = rev.size() - 1; k >= 0; k--) walk_path.push_back(rev[k]);
            end
        endcase
    endfunction

    // Applies one item to the mirror; results land in fresh_results
    function automatic void tree_apply_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                            logic [IDX_W-1:0] parent);
        logic [STS_W-1:0] st;
        int               child;
        order_t           ord;
        fresh_results.delete();
        case (op)
            OP_SET_ROOT: begin
                if (used_slots() == 0) begin
                    st = ST_BEYOND;
                end else begin
                    node_store[0] = value;
                    st = ST_OK;
                end
                fresh_results.push_back('{KIND_STATUS, st, 8'd0, 6'd0, 1'b1});
            end
            OP_SET_LEFT, OP_SET_RIGHT: begin
                child = 2 * int'(parent) + ((op == OP_SET_LEFT) ? 1 : 2);
                if (int'(parent) >= used_slots()) begin
                    st = ST_BEYOND;
                end else if (node_store[parent] == '0) begin
                    st = ST_NO_PARENT;
                end else if (child >= used_slots()) begin
                    st = ST_BEYOND;
                end else begin
                    node_store[child] = value;
                    st = ST_OK;
                end
                fresh_results.push_back('{KIND_STATUS, st, 8'd0, 6'd0, 1'b1});
            end
            OP_PREORDER, OP_INORDER, OP_POSTORDER: begin
                ord = (op == OP_PREORDER) ? ORD_PRE : (op == OP_INORDER) ? ORD_IN : ORD_POST;
                collect_walk(ord);
                if (walk_path.size() == 0) begin
                    fresh_results.push_back('{KIND_EMPTY, ST_OK, 8'd0, 6'd0, 1'b1});
                end else begin
                    foreach (walk_path[k]) begin
                        fresh_results.push_back('{KIND_VISIT, ST_OK, node_store[walk_path[k]],
                                                  IDX_W'(walk_path[k]),
                                                  k == walk_path.size() - 1});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                             input logic [IDX_W-1:0] parent, input bit typed,
                             input logic [KIND_W-1:0] kind, input logic [STS_W-1:0] status);
        s_tdata  = {7'd0, parent, value, op};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tree_apply_item(op, value, parent);
        if (typed) begin
            awaited_results.push_back('{kind, status, 8'd0, 6'd0, 1'b1});
        end else begin
            foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
        end
        @(negedge aclk);
    endtask

    // Sender idle time between items
    task automatic pace_sender();
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Size write once the block has gone quiet
    task automatic write_tree_size(input logic [IDX_W-1:0] size);
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = size;
        @(negedge aclk);
        cfg_we    = 1'b0;
        tree_size = size;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Result receiver backpressure
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        tree_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t ns: unexpected result item, tdata %h last %b",
                         $time, m_tdata, m_tlast);
                fault_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_kind",   want.kind,   m_tdata[1:0]);
                check_field("status_code",   want.status, m_tdata[3:2]);
                check_field("visited_value", want.value,  m_tdata[11:4]);
                check_field("visited_index", want.index,  m_tdata[17:12]);
                check_field("last",          want.last,   m_tlast);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("array_binary_tree_traversal_top verification failed");
            $finish;
        end
    end

    initial begin
        logic [IDX_W-1:0] phase_sizes [PHASES];
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] parent;
        int               live [$];
        int               done;
        int               r;

        foreach (node_store[i]) node_store[i] = '0;
        tree_size = 6'd63;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg) begin
                write_tree_size(PLAN[i].size);
            end else begin
                send_item(PLAN[i].op, PLAN[i].value, PLAN[i].parent, PLAN[i].typed,
                          PLAN[i].kind, PLAN[i].status);
                pace_sender();
            end
        end

        // Random part, one tree size per phase
        phase_sizes = '{6'd63, 6'd1, IDX_W'($urandom_range(2, 62)), 6'd15,
                        6'd62, IDX_W'($urandom_range(2, 62)), 6'd3, 6'd63};
        done = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_tree_size(phase_sizes[p]);
            quiet_mode = ($urandom_range(0, 3) == 0);
            while (done < (p + 1) * RANDOM_ITEMS / PHASES) begin
                live.delete();
                for (int i = 0; i < used_slots(); i++)
                    if (node_store[i] != '0) live.push_back(i);
                value  = ($urandom_range(0, 99) < 8) ? 8'd0 : VAL_W'($urandom_range(1, 255));
                parent = IDX_W'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    // noise: any opcode, any parent
                    op    = OP_W'($urandom_range(0, 7));
                    value = VAL_W'($urandom_range(0, 255));
                end else if (r < 13 || live.size() == 0) begin
                    op = OP_SET_ROOT;
                    if (live.size() == 0) value = VAL_W'($urandom_range(1, 255));
                end else if (r < 30) begin
                    op = OP_W'($urandom_range(OP_PREORDER, OP_POSTORDER));
                end else begin
                    // grow the tree under a stored node
                    op     = $urandom_range(0, 1) ? OP_SET_LEFT : OP_SET_RIGHT;
                    parent = IDX_W'(live[$urandom_range(0, live.size() - 1)]);
                end
                send_item(op, value, parent, 1'b0, KIND_STATUS, ST_OK);
                if (op != OP_SPARE_6 && op != OP_SPARE_7) done++;
                pace_sender();
            end
        end

        // Drain and finish
        s_tvalid   = 1'b0;
        quiet_mode = 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("array_binary_tree_traversal_top verification clean");
        end else begin
            $display("array_binary_tree_traversal_top verification failed");
        end
        $finish;
    end

endmodule
